### hw/rtl/vector_step_limiter_unit_macros.svh
// Assertion macros for the vector step limiter checkers
`ifndef VECTOR_STEP_LIMITER_UNIT_MACROS_SVH
`define VECTOR_STEP_LIMITER_UNIT_MACROS_SVH

// Check a same-cycle implication on clk, quiet while rst_n is low
`define VSL_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check an implication in the next cycle on clk, quiet while rst_n is low
`define VSL_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### hw/rtl/vsl_pkg.sv
// Shared types and constants for the vector step limiter
`timescale 1ns / 1ps

package vsl_pkg;

    // Fixed width of the step limit register
    localparam int MSTEP_W = 31;

    // Defaults for the top level parameters
    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // Command kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_STEP  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_F,
        ST_SQ_S,
        ST_ROOT,
        ST_CHECK,
        ST_MUL_F,
        ST_DIV_F,
        ST_MUL_S,
        ST_DIV_S,
        ST_FINISH
    } state_t;

    // What the finish cycle does to the pending vector
    typedef enum logic [1:0] {
        OP_KEEP,
        OP_LOAD,
        OP_ZERO,
        OP_MOVE
    } op_t;

    // Sequencer to datapath
    typedef struct packed {
        logic   accept;
        state_t phase;
        logic   last;
        logic   finish;
    } ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic len_tiny;
        logic len_over;
    } stat_t;

endpackage

### hw/rtl/vsl_alu.sv
// Shared add/subtract unit used by multiply, square root and divide loops
`timescale 1ns / 1ps

module vsl_alu
    import vsl_pkg::*;
#(
    parameter int WIDTH = 2 * DEF_DATA_WIDTH
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic             sub,
    output logic [WIDTH-1:0] sum,
    output logic             carry
);

    logic [WIDTH-1:0] b_eff;
    logic [WIDTH:0]   total;

    // Invert and add one for subtract; carry out means no borrow
    assign b_eff = sub ? ~b : b;
    assign total = {1'b0, a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, sub};
    assign sum   = total[WIDTH-1:0];
    assign carry = total[WIDTH];

endmodule

### hw/rtl/vsl_seq.sv
// Sequencer for the shared unit's square, root, multiply and divide loops
`timescale 1ns / 1ps

module vsl_seq
    import vsl_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  logic [1:0] kind,
    input  logic       max_zero,
    input  logic       out_free,
    input  stat_t      stat,
    output ctrl_t      ctrl
);

    localparam int MULT_W = (DATA_WIDTH > MSTEP_W) ? DATA_WIDTH : MSTEP_W;
    localparam int CNT_W  = $clog2(MULT_W);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             fire;

    assign fire = cmd_valid && (state_reg == ST_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (fire)
                begin
                    if ((kind == KIND_STEP) && !max_zero)
                        state_next = ST_SQ_F;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_SQ_F:
                if (cnt_reg == '0) state_next = ST_SQ_S;
            ST_SQ_S:
                if (cnt_reg == '0) state_next = ST_ROOT;
            ST_ROOT:
                if (cnt_reg == '0) state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (stat.len_tiny)
                    state_next = ST_FINISH;
                else if (stat.len_over)
                    state_next = ST_MUL_F;
                else
                    state_next = ST_FINISH;
            end
            ST_MUL_F:
                if (cnt_reg == '0) state_next = ST_DIV_F;
            ST_DIV_F:
                if (cnt_reg == '0) state_next = ST_MUL_S;
            ST_MUL_S:
                if (cnt_reg == '0) state_next = ST_DIV_S;
            ST_DIV_S:
                if (cnt_reg == '0) state_next = ST_FINISH;
            ST_FINISH:
                if (out_free) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Load the loop count on entry to a loop, count down inside it
    always_comb
    begin
        cnt_next = cnt_reg;
        if (state_next != state_reg)
        begin
            case (state_next)
                ST_SQ_F, ST_SQ_S, ST_ROOT, ST_DIV_F, ST_DIV_S:
                    cnt_next = CNT_W'(DATA_WIDTH - 1);
                ST_MUL_F, ST_MUL_S:
                    cnt_next = CNT_W'(MSTEP_W - 1);
                default:
                    cnt_next = '0;
            endcase
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Outputs
    always_comb
    begin
        cmd_ready   = (state_reg == ST_IDLE);
        ctrl.accept = fire;
        ctrl.phase  = state_reg;
        ctrl.last   = (cnt_reg == '0);
        ctrl.finish = (state_reg == ST_FINISH) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### hw/rtl/vector_step_limiter_unit.sv
// Top level of the vector step limiter: pending vector, workspace and result register
`timescale 1ns / 1ps
//
// Usage:
//   Command channel (cmd_valid/cmd_ready) takes one word: kind plus a vector
//   to load. Kind load replaces the pending vector, clear zeroes it, step
//   drains one length-limited step from it, and the unused kind does nothing.
//   Every word gives exactly one word on the response channel (rsp_valid/rsp_ready):
//   the step taken, moved, and still_pending. cfg_wr_en/cfg_wr_data write the step
//   limit; the user must write it only while the block is idle (unchecked).
// Work per command, all on the one add/subtract unit:
//   load, clear, no-op, or step with a zero limit: straight to the finish.
//   step within the limit or with a tiny vector: square both parts, take the root.
//   step that must be scaled: also each part times the limit, divided by the root.
//   Squaring, the square root and each divide take one bit per cycle; each limit
//   multiply steps through the bits of the limit.
// cmd_ready is high only between commands; the next command is accepted the
//   cycle after the previous response is loaded, even while it still waits.
// Reset clears the pending vector, the step limit and the response valid.
// A stalled receiver holds the response register; a finished command waits
//   in its last cycle until the register frees up.
//
module vector_step_limiter_unit
    import vsl_pkg::*;
#(
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [MSTEP_W-1:0]           cfg_wr_data,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  logic [1:0]                   kind,
    input  logic signed [DATA_WIDTH-1:0] load_forward,
    input  logic signed [DATA_WIDTH-1:0] load_side,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic signed [DATA_WIDTH-1:0] step_forward,
    output logic signed [DATA_WIDTH-1:0] step_side,
    output logic                         moved,
    output logic                         still_pending
);

    localparam int W      = DATA_WIDTH;
    localparam int MULT_W = (W > MSTEP_W) ? W : MSTEP_W;
    localparam int ACC_W  = (2 * W > W + MSTEP_W) ? 2 * W : W + MSTEP_W;
    localparam int REM_W  = W + 2;
    localparam logic [W-1:0] TINY_MAX = W'((64'd1 << FRAC_BITS) / 64'd1000);

    function automatic logic [W-1:0] magnitude(input logic [W-1:0] v);
        magnitude = v[W-1] ? (~v + W'(1)) : v;
    endfunction

    function automatic logic is_tiny(input logic [W-1:0] m);
        is_tiny = (m <= TINY_MAX);
    endfunction

    function automatic logic [W-1:0] apply_sign(input logic neg, input logic [W-1:0] q);
        apply_sign = neg ? (~q + W'(1)) : q;
    endfunction

    ctrl_t ctrl;
    stat_t stat;
    logic  out_free;
    logic  max_zero;

    // Architectural state
    logic [MSTEP_W-1:0] max_step_reg, max_step_next;
    logic [W-1:0]       pend_f_reg, pend_f_next;
    logic [W-1:0]       pend_s_reg, pend_s_next;

    // Workspace
    logic [W-1:0]      load_f_reg, load_f_next;
    logic [W-1:0]      load_s_reg, load_s_next;
    op_t               op_reg, op_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  opnd_reg, opnd_next;
    logic [MULT_W-1:0] mult_reg, mult_next;
    logic [REM_W-1:0]  rmd_reg, rmd_next;
    logic [W-1:0]      root_reg, root_next;
    logic [W-1:0]      stepf_reg, stepf_next;
    logic [W-1:0]      steps_reg, steps_next;

    // Response register
    logic         rsp_valid_reg, rsp_valid_next;
    logic [W-1:0] out_f_reg, out_f_next;
    logic [W-1:0] out_s_reg, out_s_next;
    logic         moved_reg, moved_next;
    logic         pending_reg, pending_next;

    // Shared unit
    logic [ACC_W-1:0] alu_a;
    logic [ACC_W-1:0] alu_b;
    logic             alu_sub;
    logic [ACC_W-1:0] alu_sum;
    logic             alu_carry;

    logic [W-1:0]       mag_f;
    logic [W-1:0]       mag_s;
    logic [REM_W+1:0]   root_shift;
    logic [W+1:0]       root_trial;
    logic [REM_W-1:0]   div_shift;
    logic [MULT_W-1:0]  div_q;
    logic [ACC_W-1:0]   mul_acc;
    logic [ACC_W-1:0]   acc_hi;
    logic [W-1:0]       diff_f;
    logic [W-1:0]       diff_s;
    logic               settle;
    logic [W-1:0]       new_f;
    logic [W-1:0]       new_s;

    vsl_seq #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .kind      (kind),
        .max_zero  (max_zero),
        .out_free  (out_free),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    vsl_alu #(
        .WIDTH (ACC_W)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    // Magnitudes and loop operand shapes
    assign mag_f      = magnitude(pend_f_reg);
    assign mag_s      = magnitude(pend_s_reg);
    assign root_shift = {rmd_reg, acc_reg[2*W-1 -: 2]};
    assign root_trial = {root_reg, 2'b01};
    assign div_shift  = {rmd_reg[REM_W-2:0], acc_reg[W-1]};
    assign div_q      = {mult_reg[MULT_W-2:0], alu_carry};
    assign mul_acc    = mult_reg[0] ? alu_sum : acc_reg;
    assign acc_hi     = mul_acc >> W;
    assign max_zero   = (max_step_reg == '0);
    assign out_free   = !rsp_valid_reg || rsp_ready;

    // Length status for the sequencer
    always_comb
    begin
        stat.len_tiny = is_tiny(root_reg);
        stat.len_over = MULT_W'(root_reg) > MULT_W'(max_step_reg);
    end

    // Steer the shared unit by phase
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (ctrl.phase)
            ST_SQ_F, ST_SQ_S, ST_MUL_F, ST_MUL_S:
            begin
                alu_a = acc_reg;
                alu_b = opnd_reg;
            end
            ST_ROOT:
            begin
                alu_a   = ACC_W'(root_shift);
                alu_b   = ACC_W'(root_trial);
                alu_sub = 1'b1;
            end
            ST_DIV_F, ST_DIV_S:
            begin
                alu_a   = ACC_W'(div_shift);
                alu_b   = ACC_W'(root_reg);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    // Workspace updates
    always_comb
    begin
        load_f_next = load_f_reg;
        load_s_next = load_s_reg;
        op_next     = op_reg;
        acc_next    = acc_reg;
        opnd_next   = opnd_reg;
        mult_next   = mult_reg;
        rmd_next    = rmd_reg;
        root_next   = root_reg;
        stepf_next  = stepf_reg;
        steps_next  = steps_reg;

        // Capture the word and prime the forward square
        if (ctrl.accept)
        begin
            load_f_next = load_forward;
            load_s_next = load_side;
            acc_next    = '0;
            opnd_next   = ACC_W'(mag_f);
            mult_next   = MULT_W'(mag_f);
            case (kind)
                KIND_LOAD:  op_next = OP_LOAD;
                KIND_CLEAR: op_next = OP_ZERO;
                KIND_STEP:  op_next = OP_KEEP;
                KIND_NOP:   op_next = OP_KEEP;
                default:    op_next = OP_KEEP;
            endcase
        end

        case (ctrl.phase)
            // Shift-add multiply, one multiplier bit per cycle
            ST_SQ_F, ST_SQ_S, ST_MUL_F, ST_MUL_S:
            begin
                acc_next  = mul_acc;
                opnd_next = opnd_reg << 1;
                mult_next = mult_reg >> 1;
                if (ctrl.last)
                begin
                    case (ctrl.phase)
                        ST_SQ_F:
                        begin
                            opnd_next = ACC_W'(mag_s);
                            mult_next = MULT_W'(mag_s);
                        end
                        ST_SQ_S:
                        begin
                            rmd_next  = '0;
                            root_next = '0;
                        end
                        default:
                        begin
                            rmd_next = acc_hi[REM_W-1:0];
                        end
                    endcase
                end
            end
            // Square root, two radicand bits per cycle
            ST_ROOT:
            begin
                acc_next  = acc_reg << 2;
                rmd_next  = alu_carry ? alu_sum[REM_W-1:0] : root_shift[REM_W-1:0];
                root_next = {root_reg[W-2:0], alu_carry};
            end
            // Decide: drop a tiny vector, take it whole, or scale it
            ST_CHECK:
            begin
                if (stat.len_tiny)
                begin
                    op_next = OP_ZERO;
                end
                else
                begin
                    op_next    = OP_MOVE;
                    stepf_next = pend_f_reg;
                    steps_next = pend_s_reg;
                    if (stat.len_over)
                    begin
                        acc_next  = '0;
                        opnd_next = ACC_W'(mag_f);
                        mult_next = MULT_W'(max_step_reg);
                    end
                end
            end
            // Restoring divide by the length, one quotient bit per cycle
            ST_DIV_F, ST_DIV_S:
            begin
                acc_next  = acc_reg << 1;
                rmd_next  = alu_carry ? alu_sum[REM_W-1:0] : div_shift;
                mult_next = div_q;
                if (ctrl.last)
                begin
                    if (ctrl.phase == ST_DIV_F)
                    begin
                        stepf_next = apply_sign(pend_f_reg[W-1], div_q[W-1:0]);
                        acc_next   = '0;
                        opnd_next  = ACC_W'(mag_s);
                        mult_next  = MULT_W'(max_step_reg);
                    end
                    else
                    begin
                        steps_next = apply_sign(pend_s_reg[W-1], div_q[W-1:0]);
                    end
                end
            end
            default:
            begin
                root_next = root_reg;
            end
        endcase
    end

    // Settle the pending vector after a move
    assign diff_f = pend_f_reg - stepf_reg;
    assign diff_s = pend_s_reg - steps_reg;
    assign settle = is_tiny(magnitude(diff_f)) && is_tiny(magnitude(diff_s));

    always_comb
    begin
        case (op_reg)
            OP_LOAD:
            begin
                new_f = load_f_reg;
                new_s = load_s_reg;
            end
            OP_ZERO:
            begin
                new_f = '0;
                new_s = '0;
            end
            OP_MOVE:
            begin
                new_f = settle ? '0 : diff_f;
                new_s = settle ? '0 : diff_s;
            end
            default:
            begin
                new_f = pend_f_reg;
                new_s = pend_s_reg;
            end
        endcase
    end

    // Commit state and load the response register on finish
    always_comb
    begin
        max_step_next  = cfg_wr_en ? cfg_wr_data : max_step_reg;
        pend_f_next    = pend_f_reg;
        pend_s_next    = pend_s_reg;
        out_f_next     = out_f_reg;
        out_s_next     = out_s_reg;
        moved_next     = moved_reg;
        pending_next   = pending_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (ctrl.finish)
        begin
            pend_f_next    = new_f;
            pend_s_next    = new_s;
            out_f_next     = (op_reg == OP_MOVE) ? stepf_reg : '0;
            out_s_next     = (op_reg == OP_MOVE) ? steps_reg : '0;
            moved_next     = (op_reg == OP_MOVE);
            pending_next   = (new_f != '0) || (new_s != '0);
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_step_reg  <= '0;
            pend_f_reg    <= '0;
            pend_s_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            max_step_reg  <= max_step_next;
            pend_f_reg    <= pend_f_next;
            pend_s_reg    <= pend_s_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        load_f_reg  <= load_f_next;
        load_s_reg  <= load_s_next;
        op_reg      <= op_next;
        acc_reg     <= acc_next;
        opnd_reg    <= opnd_next;
        mult_reg    <= mult_next;
        rmd_reg     <= rmd_next;
        root_reg    <= root_next;
        stepf_reg   <= stepf_next;
        steps_reg   <= steps_next;
        out_f_reg   <= out_f_next;
        out_s_reg   <= out_s_next;
        moved_reg   <= moved_next;
        pending_reg <= pending_next;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign step_forward  = out_f_reg;
    assign step_side     = out_s_reg;
    assign moved         = moved_reg;
    assign still_pending = pending_reg;

endmodule

### hw/rtl/vsl_checker.sv
// Port-level checker for the vector step limiter, bound to the top level
`timescale 1ns / 1ps
`include "vector_step_limiter_unit_macros.svh"

module vsl_checker
    import vsl_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cmd_valid,
    input logic                  cmd_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [DATA_WIDTH-1:0] step_forward,
    input logic [DATA_WIDTH-1:0] step_side,
    input logic                  moved,
    input logic                  still_pending
);

    // Hold a stalled response word
    `VSL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(step_forward) && $stable(step_side) && $stable(moved) && $stable(still_pending), "response changed while stalled")

    // A word without a move carries a zero step
    `VSL_ASSERT_SAME(a_no_move_zero, rsp_valid && !moved, step_forward == 0 && step_side == 0, "nonzero step without a move")

    // Drop ready in the cycle after taking a command
    `VSL_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "ready right after accept")

    // A new response shows up only as the block returns to idle
    `VSL_ASSERT_SAME(a_rsp_at_idle, $rose(rsp_valid), cmd_ready, "response raised while busy")

endmodule

bind vector_step_limiter_unit vsl_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_vsl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .step_forward  (step_forward),
    .step_side     (step_side),
    .moved         (moved),
    .still_pending (still_pending)
);

### test/tb_vector_step_limiter_unit.sv
// Testbench for the vector step limiter: directed and random commands checked against a predictor
`timescale 1ns / 1ps

module tb_vector_step_limiter_unit;
    import vsl_pkg::*;

    localparam int W           = DEF_DATA_WIDTH;
    localparam int FB          = DEF_FRAC_BITS;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 500;
    localparam int TAIL_CYCLES = 240;

    // One response word as the block reports it
    typedef struct packed {
        logic [W-1:0] fwd;
        logic [W-1:0] side;
        logic         moved;
        logic         pending;
    } step_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [MSTEP_W-1:0]   cfg_wr_data = '0;
    logic                 cmd_valid = 1'b0;
    logic                 cmd_ready;
    logic [1:0]           kind = KIND_LOAD;
    logic [W-1:0]         load_forward = '0;
    logic [W-1:0]         load_side = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    logic [W-1:0]         step_forward;
    logic [W-1:0]         step_side;
    logic                 moved;
    logic                 still_pending;

    // Predictor state: pending vector and step limit
    logic [W-1:0]         pend_fwd = '0;
    logic [W-1:0]         pend_side = '0;
    logic [MSTEP_W-1:0]   step_limit = '0;

    step_result_t         expected_steps[$];
    step_result_t         want_word;
    step_result_t         got_word;
    int                   bad_words = 0;
    int                   quiet_cycles = 0;
    int                   burst_left = 8;

    // Receiver pattern state
    bit                   hold_request = 1'b0;
    int                   hold_left = 0;
    int                   rx_mode = 0;
    int                   rx_mode_left = 0;
    logic [2:0]           rx_tick = '0;

    vector_step_limiter_unit #(
        .FRAC_BITS  (FB),
        .DATA_WIDTH (W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .kind          (kind),
        .load_forward  (load_forward),
        .load_side     (load_side),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .step_forward  (step_forward),
        .step_side     (step_side),
        .moved         (moved),
        .still_pending (still_pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [W-1:0] magnitude(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // Raw value at or below 0.001 in the fixed-point scale
    function automatic bit below_threshold(input logic [W-1:0] m);
        logic [2*W-1:0] scaled;
        logic [2*W-1:0] one;
        scaled = m;
        scaled = scaled * 1000;
        one = 1;
        one = one << FB;
        return scaled <= one;
    endfunction

    // Floor of the square root, two bits per round
    function automatic logic [W-1:0] root_floor(input logic [2*W-1:0] x);
        logic [W+2:0] rem;
        logic [W+2:0] trial;
        logic [W-1:0] root;
        rem = '0;
        root = '0;
        for (int i = W - 1; i >= 0; i--)
        begin
            rem = {rem[W:0], x[2*i +: 2]};
            trial = {1'b0, root, 2'b01};
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = {root[W-2:0], 1'b1};
            end
            else
            begin
                root = {root[W-2:0], 1'b0};
            end
        end
        return root;
    endfunction

    // Shrink one part by step_limit / len, truncating the magnitude
    function automatic logic [W-1:0] scale_part(input logic [W-1:0] part,
                                                input logic [W-1:0] len);
        logic [2*W-1:0] prod;
        logic [2*W-1:0] wide_len;
        logic [2*W-1:0] quot;
        prod = magnitude(part);
        prod = prod * step_limit;
        wide_len = len;
        quot = prod / wide_len;
        return part[W-1] ? (~quot[W-1:0] + 1'b1) : quot[W-1:0];
    endfunction

    // Advance the pending vector by one command and return its response word
    function automatic step_result_t apply_command(input logic [1:0] k,
                                                   input logic [W-1:0] f,
                                                   input logic [W-1:0] s);
        step_result_t   r;
        logic [2*W-1:0] sq_f;
        logic [2*W-1:0] sq_s;
        logic [W-1:0]   len;
        r = '0;
        case (k)
            KIND_LOAD:
            begin
                pend_fwd = f;
                pend_side = s;
            end
            KIND_CLEAR:
            begin
                pend_fwd = '0;
                pend_side = '0;
            end
            KIND_STEP:
            begin
                if (step_limit != 0)
                begin
                    sq_f = magnitude(pend_fwd);
                    sq_f = sq_f * sq_f;
                    sq_s = magnitude(pend_side);
                    sq_s = sq_s * sq_s;
                    len = root_floor(sq_f + sq_s);
                    if (below_threshold(len))
                    begin
                        pend_fwd = '0;
                        pend_side = '0;
                    end
                    else
                    begin
                        if (len > step_limit)
                        begin
                            r.fwd = scale_part(pend_fwd, len);
                            r.side = scale_part(pend_side, len);
                        end
                        else
                        begin
                            r.fwd = pend_fwd;
                            r.side = pend_side;
                        end
                        r.moved = 1'b1;
                        pend_fwd = pend_fwd - r.fwd;
                        pend_side = pend_side - r.side;
                        // Settle once both parts are negligible
                        if (below_threshold(magnitude(pend_fwd)) &&
                            below_threshold(magnitude(pend_side)))
                        begin
                            pend_fwd = '0;
                            pend_side = '0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.pending = (pend_fwd != 0) || (pend_side != 0);
        return r;
    endfunction

    // ---------------------------------------------------------------- sender

    // Present one word, hold it until taken, then log its expected response
    task automatic send_command(input logic [1:0] k, input logic [W-1:0] f,
                                input logic [W-1:0] s);
        step_result_t r;
        @(negedge clk);
        cmd_valid <= 1'b1;
        kind <= k;
        load_forward <= f;
        load_side <= s;
        do
            @(posedge clk);
        while (!cmd_ready);
        r = apply_command(k, f, s);
        expected_steps.push_back(r);
    endtask

    // Drop valid and keep it low for a pause set by n
    task automatic sender_pause(input int n);
        @(negedge clk);
        cmd_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Send within a burst; maybe insert a random gap when the burst runs out
    task automatic offer_command(input logic [1:0] k, input logic [W-1:0] f,
                                 input logic [W-1:0] s);
        send_command(k, f, s);
        burst_left--;
        if (burst_left <= 0)
        begin
            if ($urandom_range(0, 3) != 0)
                sender_pause($urandom_range(1, 15));
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Stop sending and wait for every response to come back
    task automatic wait_drained();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (expected_steps.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_step_limit(input logic [MSTEP_W-1:0] v);
        wait_drained();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        step_limit = v;
    endtask

    function automatic logic [W-1:0] random_part(input longint unsigned span);
        longint unsigned v;
        logic [W-1:0]    p;
        v = {$urandom, $urandom};
        v = v % (span + 1);
        p = v[W-1:0];
        if ($urandom_range(0, 1) == 1)
            p = ~p + 1'b1;
        return p;
    endfunction

    // ---------------------------------------------------------------- receiver

    // Stall on a changing pattern; honor a long hold when asked
    always @(negedge clk)
    begin
        rx_tick = rx_tick + 1'b1;
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(32, 400);
            end
            else
            begin
                rx_mode_left--;
            end
            case (rx_mode)
                0: rsp_ready <= 1'b1;
                1: rsp_ready <= $urandom_range(0, 1);
                2: rsp_ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ready <= rx_tick[2];
            endcase
        end
    end

    // ---------------------------------------------------------------- checking

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            got_word = {step_forward, step_side, moved, still_pending};
            if (expected_steps.size() == 0)
            begin
                bad_words++;
                if (bad_words <= 10)
                    $display("unexpected response word: fwd=%h side=%h moved=%b pending=%b",
                             got_word.fwd, got_word.side, got_word.moved, got_word.pending);
            end
            else
            begin
                want_word = expected_steps.pop_front();
                if (got_word.fwd !== want_word.fwd || got_word.side !== want_word.side ||
                    got_word.moved !== want_word.moved ||
                    got_word.pending !== want_word.pending)
                begin
                    bad_words++;
                    if (bad_words <= 10)
                        $display({"step word mismatch at %0t: expected fwd=%h side=%h ",
                                  "moved=%b pending=%b, got fwd=%h side=%h moved=%b ",
                                  "pending=%b"},
                                 $realtime, want_word.fwd, want_word.side,
                                 want_word.moved, want_word.pending, got_word.fwd,
                                 got_word.side, got_word.moved, got_word.pending);
                end
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) || cfg_wr_en)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // Limit still at its reset value of zero: steps must refuse to move
    task automatic test_zero_limit();
        send_command(KIND_STEP, '0, '0);
        send_command(KIND_LOAD, 32'h0001_2345, 32'hFFFF_5433);
        send_command(KIND_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(KIND_NOP, 32'hFFFF_FFFF, 32'h0000_0000);
        send_command(KIND_CLEAR, 32'h5555_5555, 32'hAAAA_AAAA);
        send_command(KIND_STEP, '0, '0);
    endtask

    // Field extremes, threshold edges and settling at several limits
    task automatic test_limit_edges();
        set_step_limit(31'd65536);
        send_command(KIND_LOAD, 32'h7FFF_FFFF, 32'h8000_0000);
        send_command(KIND_STEP, '0, '0);
        send_command(KIND_STEP, '0, '0);
        send_command(KIND_LOAD, 32'h8000_0000, 32'h8000_0000);
        send_command(KIND_STEP, '0, '0);
        // length 65 is tiny, 66 is not
        send_command(KIND_LOAD, 32'd65, 32'd0);
        send_command(KIND_STEP, '0, '0);
        send_command(KIND_LOAD, 32'd0, -32'sd66);
        send_command(KIND_STEP, '0, '0);
        // scaled step leaves a negligible remainder that settles to zero
        send_command(KIND_LOAD, 32'd65566, 32'd20);
        send_command(KIND_STEP, '0, '0);
        send_command(KIND_LOAD, -32'sd100, 32'd100);
        send_command(KIND_NOP, '0, '0);
        send_command(KIND_STEP, '0, '0);

        set_step_limit(31'h7FFF_FFFF);
        send_command(KIND_LOAD, 32'h8000_0000, 32'h8000_0000);
        send_command(KIND_STEP, '0, '0);
        send_command(KIND_STEP, '0, '0);
        send_command(KIND_LOAD, 32'h7FFF_FFFF, 32'd0);
        send_command(KIND_STEP, '0, '0);

        // smallest limit: scaled parts truncate to zero but still count as a move
        set_step_limit(31'd1);
        send_command(KIND_LOAD, 32'd1000, -32'sd1000);
        send_command(KIND_STEP, '0, '0);
        send_command(KIND_STEP, '0, '0);
    endtask

    // Load-then-drain sequences with random content, plus clears and stray kinds
    task automatic run_drain_phase(input logic [MSTEP_W-1:0] limit, input int quota);
        int              count;
        int              n;
        int              pick;
        int              steps_cap;
        longint unsigned span;
        logic [W-1:0]    f;
        logic [W-1:0]    s;
        set_step_limit(limit);
        count = 0;
        while (count < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                offer_command(KIND_CLEAR, $urandom, $urandom);
                count++;
            end
            else if (pick < 10)
            begin
                offer_command(KIND_NOP, $urandom, $urandom);
                count++;
            end
            else if (pick < 14)
            begin
                offer_command(KIND_STEP, $urandom, $urandom);
                count++;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        f = $urandom;
                        s = $urandom;
                    end
                    1:
                    begin
                        span = limit;
                        span = span * $urandom_range(1, 6);
                        if (span > 64'h8000_0000)
                            span = 64'h8000_0000;
                        f = random_part(span);
                        s = random_part(span);
                    end
                    2:
                    begin
                        f = random_part(200);
                        s = random_part(200);
                    end
                    default:
                    begin
                        span = limit / 2;
                        f = random_part(span);
                        s = random_part(span);
                    end
                endcase
                if ($urandom_range(0, 7) == 0)
                    f = '0;
                else if ($urandom_range(0, 7) == 0)
                    s = '0;
                offer_command(KIND_LOAD, f, s);
                count++;
                steps_cap = $urandom_range(1, 8);
                n = 0;
                do
                begin
                    offer_command(KIND_STEP, $urandom, $urandom);
                    n++;
                    count++;
                end
                while ((pend_fwd != 0 || pend_side != 0) && n < steps_cap);
            end
        end
    endtask

    task automatic test_random_drain();
        run_drain_phase(31'd1, 235);
        run_drain_phase(31'd65536, 235);
        run_drain_phase(31'h7FFF_FFFF, 235);
        run_drain_phase(31'd0, 235);
        run_drain_phase(MSTEP_W'($urandom_range(2, 32'h0010_0000)), 235);
        run_drain_phase(MSTEP_W'($urandom & 32'h7FFF_FFFF), 235);
        run_drain_phase(31'd66, 235);
        run_drain_phase(MSTEP_W'($urandom_range(32'h0001_0000, 32'h0100_0000)), 235);
    endtask

    // Hold the receiver off while words keep coming, so the input stalls
    task automatic test_backpressure();
        set_step_limit(31'd40000);
        hold_request = 1'b1;
        for (int i = 0; i < 24; i++)
        begin
            if (i % 3 == 0)
                send_command(KIND_LOAD, random_part(200000), random_part(200000));
            else
                send_command(KIND_STEP, $urandom, $urandom);
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_zero_limit();
        test_limit_edges();
        test_backpressure();
        test_random_drain();

        // drain, then give the block time to show any stray word
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_steps.size() != 0)
            bad_words++;
        if (bad_words == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/vsl_pkg.sv
hw/rtl/vsl_alu.sv
hw/rtl/vsl_seq.sv
hw/rtl/vector_step_limiter_unit.sv
hw/rtl/vsl_checker.sv
test/tb_vector_step_limiter_unit.sv
